// ----- rtl/core/osa_pkg.sv -----
// owner tagged slot allocator: shared constants, request and status codes
// no dependencies; used by owner_tagged_slot_allocator, slot_result_checker and the testbench
package osa_pkg;

  // parameter defaults
  localparam int SLOTS_DEFAULT    = 1024;
  localparam int TAG_BITS_DEFAULT = 16;

  // field widths fixed by the stream format
  localparam int FUNC_W   = 2;
  localparam int TAG_W    = 16;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  // register reset value
  localparam logic [COUNT_W-1:0] SEATS_RESET = 11'd1024;

  // free slot marker
  localparam int LIBRE = 0;

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TAG   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

endpackage

// ----- rtl/core/owner_tagged_slot_allocator.sv -----
// owner tagged first-fit slot allocator: table memory, scan sequencer, result register
// depends on osa_pkg
//
// input words (s_axis) carry a request: reserve puts owner_tag into the lowest free
// slot in use, release frees slot_index and returns its tag, query reads slot_index.
// output words (m_axis) carry one result per request: status, granted slot, held tag
// and the free and occupied counts after the request.
// cfg_we/cfg_wdata write the number of slots in use (clamped to SLOTS) and start a
// clear of the whole table; write it only while no request is in flight.
// zero-tag, full, out-of-range and unknown requests are answered without a table
// access; release and query read their slot first; a reserve walks the table one
// slot a cycle through the single table port until it finds a free slot. one
// request is worked at a time.
// after reset and after every register write the table is cleared one slot a cycle,
// with s_axis_tready low.
// a finished result waits in the output register while m_axis_tready is low; the
// next request is taken meanwhile and its result is held back until the slot opens.
module owner_tagged_slot_allocator #(
  parameter int SLOTS    = osa_pkg::SLOTS_DEFAULT,
  parameter int TAG_BITS = osa_pkg::TAG_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func[1:0], owner_tag[17:2], slot_index[27:18], zero fill
  input  logic [osa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0], granted_slot[12:3], held_tag[28:13], free_slots[39:29],
  // taken_slots[50:40], zero fill
  output logic [osa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [osa_pkg::COUNT_W-1:0]       cfg_wdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = osa_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [TAG_BITS-1:0] mem [SLOTS];
  logic [TAG_BITS-1:0] rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [TAG_BITS-1:0] mem_wd;
  logic [AW-1:0]       rd_addr;

  logic [CW-1:0] seats;
  logic [CW-1:0] taken;
  logic [AW-1:0] clr_addr;
  logic [AW:0]   scan_addr;
  logic [AW:0]   chk_addr;
  logic          chk_vld;

  logic [osa_pkg::FUNC_W-1:0]  func_q;
  logic [TAG_BITS-1:0]         tag_q;
  logic [osa_pkg::INDEX_W-1:0] idx_q;

  logic [osa_pkg::STATUS_W-1:0] res_status;
  logic [osa_pkg::INDEX_W-1:0]  res_granted;
  logic [osa_pkg::TAG_W-1:0]    res_held;

  logic [osa_pkg::STATUS_W-1:0] out_status;
  logic [osa_pkg::INDEX_W-1:0]  out_granted;
  logic [osa_pkg::TAG_W-1:0]    out_held;
  logic [CW-1:0]                out_free;
  logic [CW-1:0]                out_taken;

  logic [osa_pkg::FUNC_W-1:0]  in_func;
  logic [osa_pkg::TAG_W-1:0]   in_tag_raw;
  logic [TAG_BITS-1:0]         in_tag;
  logic [osa_pkg::INDEX_W-1:0] in_idx;
  logic                        accept;
  logic                        idx_out;
  logic                        found;
  logic                        issue_ok;
  logic                        out_free_slot;
  logic [CW-1:0]               seats_clamped;

  assign in_func    = s_axis_tdata[1:0];
  assign in_tag_raw = s_axis_tdata[17:2];
  assign in_idx     = s_axis_tdata[27:18];
  assign in_tag     = TAG_BITS'(in_tag_raw);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_out       = (CW'(in_idx) >= seats);
  assign found         = (state == S_SCAN) && chk_vld && (rdata == TAG_BITS'(osa_pkg::LIBRE));
  assign issue_ok      = (32'(scan_addr) < 32'(seats));
  assign out_free_slot = !m_axis_tvalid || m_axis_tready;

  assign seats_clamped = (32'(cfg_wdata) > SLOTS) ? CW'(SLOTS) : cfg_wdata;

  // table port: one write and one registered read per cycle
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = clr_addr;
    mem_wd  = TAG_BITS'(osa_pkg::LIBRE);
    rd_addr = scan_addr[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        rd_addr = AW'(in_idx);
      end
      S_LOOK: begin
        mem_wa = AW'(idx_q);
        if (func_q == osa_pkg::FUNC_RELEASE && rdata != TAG_BITS'(osa_pkg::LIBRE)) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN: begin
        mem_wa = chk_addr[AW-1:0];
        mem_wd = tag_q;
        mem_we = found;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      seats         <= (32'(osa_pkg::SEATS_RESET) > SLOTS) ? CW'(SLOTS) : osa_pkg::SEATS_RESET;
      taken         <= '0;
      chk_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q      <= in_func;
            tag_q       <= in_tag;
            idx_q       <= in_idx;
            res_status  <= osa_pkg::ST_OK;
            res_granted <= '0;
            res_held    <= '0;
            scan_addr   <= '0;
            chk_vld     <= 1'b0;
            case (in_func)
              osa_pkg::FUNC_RESERVE: begin
                if (in_tag == TAG_BITS'(osa_pkg::LIBRE)) begin
                  res_status <= osa_pkg::ST_ZERO_TAG;
                  state      <= S_DONE;
                end else if (taken >= seats) begin
                  res_status <= osa_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              osa_pkg::FUNC_RELEASE, osa_pkg::FUNC_QUERY: begin
                if (idx_out) begin
                  res_status <= osa_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_LOOK;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOOK: begin
          // read data for idx_q is in rdata now
          if (func_q == osa_pkg::FUNC_RELEASE) begin
            if (rdata == TAG_BITS'(osa_pkg::LIBRE)) begin
              res_status <= osa_pkg::ST_ALREADY_FREE;
            end else begin
              res_held <= osa_pkg::TAG_W'(rdata);
              if (taken != '0) begin
                taken <= taken - 1'b1;
              end
            end
          end else begin
            res_held <= osa_pkg::TAG_W'(rdata);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // issue one read a cycle, check the word read the cycle before
          chk_addr <= scan_addr;
          chk_vld  <= issue_ok;
          if (issue_ok) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (found) begin
            taken       <= taken + 1'b1;
            res_granted <= osa_pkg::INDEX_W'(chk_addr);
            chk_vld     <= 1'b0;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free_slot) begin
            out_status    <= res_status;
            out_granted   <= res_granted;
            out_held      <= res_held;
            out_free      <= seats - taken;
            out_taken     <= taken;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // register write restarts the table clear
      if (cfg_we) begin
        seats    <= seats_clamped;
        taken    <= '0;
        clr_addr <= '0;
        chk_vld  <= 1'b0;
        state    <= S_CLEAR;
      end
    end
  end

  assign m_axis_tdata = {5'd0, out_taken, out_free, out_held, out_granted, out_status};

endmodule

// ----- tb/slot_result_checker.sv -----
// slot allocator checker: tracks the slot table from accepted request words and
// compares every result word with its prediction; depends on osa_pkg
`timescale 1ns / 100ps

module slot_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [osa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [osa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [osa_pkg::COUNT_W-1:0]    cfg_wdata,
  output int                             fails,
  output int                             pending
);
  import osa_pkg::*;

  // status sits in the low bits, as on the bus
  typedef struct packed {
    logic [COUNT_W-1:0]  taken;
    logic [COUNT_W-1:0]  free;
    logic [TAG_W-1:0]    held;
    logic [INDEX_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  localparam int OUTCOME_W = $bits(outcome_t);

  logic [TAG_W-1:0] owner_of [SLOTS_DEFAULT];
  int unsigned      seats;
  int unsigned      occupied;
  outcome_t         due_results [$];

  function automatic void wipe_table();
    foreach (owner_of[k]) owner_of[k] = '0;
    occupied = 0;
  endfunction

  function automatic outcome_t serve_request(input logic [FUNC_W-1:0] f,
                                             input logic [TAG_W-1:0] tag,
                                             input logic [INDEX_W-1:0] idx);
    outcome_t o;
    o = '0;
    case (f)
      FUNC_RESERVE: begin
        if (tag == LIBRE) begin
          o.status = ST_ZERO_TAG;
        end else begin
          o.status = ST_FULL;
          // first fit over the slots in use
          for (int k = 0; k < seats; k++) begin
            if (owner_of[k] == LIBRE) begin
              owner_of[k] = tag;
              occupied++;
              o.granted = INDEX_W'(k);
              o.status = ST_OK;
              break;
            end
          end
        end
      end
      FUNC_RELEASE: begin
        if (idx >= seats) begin
          o.status = ST_RANGE;
        end else if (owner_of[idx] == LIBRE) begin
          o.status = ST_ALREADY_FREE;
        end else begin
          o.held = owner_of[idx];
          owner_of[idx] = '0;
          if (occupied > 0) occupied--;
        end
      end
      FUNC_QUERY: begin
        if (idx >= seats) o.status = ST_RANGE;
        else o.held = owner_of[idx];
      end
      default: ;
    endcase
    o.free  = COUNT_W'(seats - occupied);
    o.taken = COUNT_W'(occupied);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      wipe_table();
      seats = (SEATS_RESET > SLOTS_DEFAULT) ? SLOTS_DEFAULT : SEATS_RESET;
      due_results.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        seats = (cfg_wdata > SLOTS_DEFAULT) ? SLOTS_DEFAULT : cfg_wdata;
        wipe_table();
      end
      // results are registered behind their request, so check first
      if (m_axis_tvalid && m_axis_tready) begin
        got = outcome_t'(m_axis_tdata[OUTCOME_W-1:0]);
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word: status %0d slot %0d tag %h free %0d taken %0d",
                     got.status, got.granted, got.held, got.free, got.taken);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.held !== want.held || got.free !== want.free ||
              got.taken !== want.taken) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected status %0d slot %0d tag %h free %0d taken %0d, %s",
                       want.status, want.granted, want.held, want.free, want.taken,
                       $sformatf("got status %0d slot %0d tag %h free %0d taken %0d",
                                 got.status, got.granted, got.held, got.free, got.taken));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(serve_request(s_axis_tdata[1:0], s_axis_tdata[17:2],
                                            s_axis_tdata[27:18]));
    end
    pending = due_results.size();
  end

endmodule

// ----- tb/owner_tagged_slot_allocator_tb.sv -----
// testbench top for owner_tagged_slot_allocator: drives request words, the slot
// count register and the result stall; depends on osa_pkg and slot_result_checker
`timescale 1ns / 100ps

module owner_tagged_slot_allocator_tb;
  import osa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  // longest quiet stretch: a table clear or a full scan plus a stall, many times over
  localparam int QUIET_LIMIT = 8000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 44;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;

  int fails;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int seats_now = SLOTS_DEFAULT;
  int quiet = 0;

  always #5 clk = ~clk;

  owner_tagged_slot_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  slot_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fails         (fails),
    .pending       (pending)
  );

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic set_pace(input int mode);
    case (mode)
      1: begin gap_pct = 47; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 47; end
      3: begin gap_pct = 35; stall_pct = 35; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the handshake
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [TAG_W-1:0] tag,
                              input logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, idx, tag, f};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // the register write clears the table, so every result has to be in first
  task automatic write_seats(input logic [COUNT_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    seats_now = (v > SLOTS_DEFAULT) ? SLOTS_DEFAULT : v;
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int hi;
    if (seats_now == 0) return INDEX_W'($urandom_range(0, 1023));
    hi = seats_now - 1;
    // occupied slots cluster low under first fit
    if ($urandom_range(0, 1) == 0 && hi > 63) hi = 63;
    return INDEX_W'($urandom_range(0, hi));
  endfunction

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      send_request(FUNC_RESERVE, '0, INDEX_W'($urandom_range(0, 1023)));
    else if (r < 48)
      send_request(FUNC_RESERVE, TAG_W'($urandom_range(1, 65535)),
                   INDEX_W'($urandom_range(0, 1023)));
    else if (r < 75)
      send_request(FUNC_RELEASE, TAG_W'($urandom_range(0, 65535)), pick_index());
    else if (r < 90)
      send_request(FUNC_QUERY, TAG_W'($urandom_range(0, 65535)), pick_index());
    else if (r < 95)
      send_request(FUNC_W'($urandom_range(1, 2)), TAG_W'($urandom_range(0, 65535)),
                   INDEX_W'($urandom_range(0, 1023)));
    else
      send_request(FUNC_UNKNOWN, TAG_W'($urandom_range(0, 65535)),
                   INDEX_W'($urandom_range(0, 1023)));
  endtask

  initial begin
    int seat_plan [PHASES];
    seat_plan = '{3, 8, 2047, 1, 16, 64, 2, 1024, 33, 5, 0, 12};
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // all slots in use after reset
    send_request(FUNC_RESERVE, '0, '0);
    send_request(FUNC_RESERVE, 16'hFFFF, 10'h3FF);
    send_request(FUNC_RESERVE, 16'h0001, '0);
    send_request(FUNC_QUERY, '0, 10'd0);
    send_request(FUNC_QUERY, '0, 10'd1023);
    send_request(FUNC_RELEASE, '0, 10'd0);
    send_request(FUNC_RELEASE, '0, 10'd0);
    send_request(FUNC_RESERVE, 16'h8000, '0);
    send_request(FUNC_UNKNOWN, 16'hFFFF, 10'h3FF);
    // no slot in use
    write_seats(11'd0);
    send_request(FUNC_RESERVE, 16'h1234, '0);
    send_request(FUNC_RELEASE, '0, 10'd0);
    send_request(FUNC_QUERY, '0, 10'd1023);
    write_seats(11'd1);
    send_request(FUNC_RESERVE, 16'h0007, '0);
    send_request(FUNC_RESERVE, 16'h0009, '0);
    send_request(FUNC_QUERY, '0, 10'd1);
    send_request(FUNC_RELEASE, '0, 10'd0);
    // zero tag is reported even when the table is full
    write_seats(11'd2);
    send_request(FUNC_RESERVE, 16'h0003, '0);
    send_request(FUNC_RESERVE, 16'h0004, '0);
    send_request(FUNC_RESERVE, '0, '0);
    send_request(FUNC_RESERVE, 16'h0005, '0);
    send_request(FUNC_RELEASE, '0, 10'd1);
    send_request(FUNC_QUERY, '0, 10'd1);
    // register above the table size is clamped
    write_seats(11'd2047);
    send_request(FUNC_QUERY, '0, 10'd1023);
    send_request(FUNC_RESERVE, 16'h0002, '0);

    for (int p = 0; p < PHASES; p++) begin
      set_pace(p % 4);
      write_seats(COUNT_W'(seat_plan[p]));
      repeat (PHASE_WORDS) send_random_request();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
